// ===== rtl/overwriting_ring_fifo_top_defines.svh =====
// Assertion macros for the ring FIFO top level.
`ifndef OVERWRITING_RING_FIFO_TOP_DEFINES_SVH
`define OVERWRITING_RING_FIFO_TOP_DEFINES_SVH

// Checked on every rising edge of clk, but not while reset is asserted.
`define ORF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ORF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/orf_pkg.sv =====
// Types and constants for the overwriting ring FIFO.
package orf_pkg;

	localparam int ORF_DEPTH   = 16;
	localparam int ORF_ENTRY_W = 32;
	localparam int ORF_PTR_W   = $clog2(ORF_DEPTH);
	localparam int ORF_CNT_W   = $clog2(ORF_DEPTH + 1);

	typedef enum logic [1:0] {
		ORF_CMD_PUSH        = 2'd0,
		ORF_CMD_POP         = 2'd1,
		ORF_CMD_PEEK_OLDEST = 2'd2,
		ORF_CMD_PEEK_NEWEST = 2'd3
	} orf_cmd_t;

	typedef enum logic [1:0] {
		ORF_ST_OK          = 2'd0,
		ORF_ST_OVERWRITTEN = 2'd1,
		ORF_ST_EMPTY       = 2'd2
	} orf_status_t;

	typedef struct packed {
		orf_cmd_t                 cmd;
		logic [ORF_ENTRY_W-1:0]   push_data;
	} orf_req_t;

	typedef struct packed {
		orf_status_t              status;
		logic [ORF_ENTRY_W-1:0]   read_data;
		logic [ORF_CNT_W-1:0]     entry_count;
	} orf_rsp_t;

endpackage

// ===== rtl/overwriting_ring_fifo_top.sv =====
// Top level of the overwriting ring FIFO: pointers, count and response pipeline.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_valid/req_stall | orf_req_t  (cmd, push_data)
//  rsp     | out       | rsp_valid/rsp_stall | orf_rsp_t  (status, read_data, entry_count)
//
// One command is taken per cycle unless req is stalled; it passes the first stage,
// where the entry RAM's registered read data arrives, then the response register.
// Pointers and count update as the command is taken, so a push in one cycle is seen
// by a peek or pop in the next. Reset clears oldest and count at once and sets
// newest to the last slot, not the RAM. rsp_stall holds the pipeline, stalls req.
module overwriting_ring_fifo_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  orf_pkg::orf_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output orf_pkg::orf_rsp_t rsp
);

	import orf_pkg::*;

	`include "overwriting_ring_fifo_top_defines.svh"

	logic [ORF_PTR_W-1:0]   oldest_q;
	logic [ORF_PTR_W-1:0]   newest_q;
	logic [ORF_CNT_W-1:0]   count_q;

	logic                   s1_valid_s1;
	orf_status_t            s1_status_s1;
	logic                   s1_use_rd_s1;
	logic [ORF_CNT_W-1:0]   s1_count_s1;

	logic                   out_valid_q;
	orf_rsp_t               out_q;

	logic                   accept;
	logic                   s1_adv;
	logic                   is_empty;
	logic                   is_full;
	logic [ORF_PTR_W-1:0]   oldest_next;
	logic [ORF_PTR_W-1:0]   newest_next;
	logic                   ram_we;
	logic                   ram_re;
	logic [ORF_PTR_W-1:0]   ram_raddr;
	logic [ORF_ENTRY_W-1:0] ram_rdata;
	orf_status_t            status_d;
	logic                   use_rd_d;
	logic [ORF_CNT_W-1:0]   count_d;
	logic [ORF_PTR_W-1:0]   oldest_d;
	logic [ORF_PTR_W:0]     chk_sum;
	logic [ORF_PTR_W-1:0]   chk_slot;

	function automatic logic [ORF_PTR_W-1:0] next_slot(input logic [ORF_PTR_W-1:0] slot);
		if (slot == ORF_PTR_W'(ORF_DEPTH - 1)) begin
			return '0;
		end
		return slot + 1'b1;
	endfunction

	assign s1_adv    = s1_valid_s1 && (!out_valid_q || !rsp_stall);
	assign req_stall = s1_valid_s1 && !s1_adv;
	assign accept    = req_valid && !req_stall;

	assign is_empty    = (count_q == '0);
	assign is_full     = (count_q == ORF_CNT_W'(ORF_DEPTH));
	assign oldest_next = next_slot(oldest_q);
	assign newest_next = next_slot(newest_q);

	always_comb begin
		status_d  = ORF_ST_OK;
		use_rd_d  = 1'b0;
		count_d   = count_q;
		oldest_d  = oldest_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = oldest_q;
		unique case (req.cmd) inside
			ORF_CMD_PUSH: begin
				ram_we = accept;
				if (is_full) begin
					status_d = ORF_ST_OVERWRITTEN;
					oldest_d = oldest_next;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			ORF_CMD_POP, ORF_CMD_PEEK_OLDEST, ORF_CMD_PEEK_NEWEST: begin
				if (is_empty) begin
					status_d = ORF_ST_EMPTY;
				end else begin
					use_rd_d = 1'b1;
					ram_re   = accept;
					if (req.cmd == ORF_CMD_PEEK_NEWEST) begin
						ram_raddr = newest_q;
					end
					if (req.cmd == ORF_CMD_POP) begin
						oldest_d = oldest_next;
						count_d  = count_q - 1'b1;
					end
				end
			end
			default: begin
				status_d = ORF_ST_OK;
			end
		endcase
	end

	orf_ram #(
		.WIDTH (ORF_ENTRY_W),
		.DEPTH (ORF_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (newest_next),
		.wdata (req.push_data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= ORF_PTR_W'(ORF_DEPTH - 1);
			count_q  <= '0;
		end else if (accept) begin
			oldest_q <= oldest_d;
			count_q  <= count_d;
			if (req.cmd == ORF_CMD_PUSH) begin
				newest_q <= newest_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_status_s1 <= status_d;
			s1_use_rd_s1 <= use_rd_d;
			s1_count_s1  <= count_d;
		end
		// The RAM read data is only valid while the transaction sits in the first stage.
		if (s1_adv) begin
			out_q.status      <= s1_status_s1;
			out_q.read_data   <= s1_use_rd_s1 ? ram_rdata : '0;
			out_q.entry_count <= s1_count_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// The oldest slot plus the count, taken round the ring, lands one past the newest.
	assign chk_sum  = {1'b0, oldest_q} + (ORF_PTR_W + 1)'(count_q);
	assign chk_slot = (chk_sum >= (ORF_PTR_W + 1)'(ORF_DEPTH)) ?
		ORF_PTR_W'(chk_sum - (ORF_PTR_W + 1)'(ORF_DEPTH)) : chk_sum[ORF_PTR_W-1:0];

	`ORF_ASSERT(a_count_range, count_q <= ORF_CNT_W'(ORF_DEPTH), "entry count beyond depth")
	`ORF_ASSERT(a_ring_consistent, chk_slot == newest_next, "pointers disagree with count")
	`ORF_ASSERT(a_no_accept_when_held, (s1_valid_s1 && !s1_adv) |-> !accept,
		"transaction accepted while first stage is held")
	`ORF_ASSERT(a_empty_has_zero, (rsp_valid && rsp.status == ORF_ST_EMPTY) |->
		(rsp.entry_count == '0 && rsp.read_data == '0), "empty response with data or count")
	`ORF_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!s1_valid_s1 && !out_valid_q),
		"pipeline valid after reset")

endmodule

// ===== rtl/orf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module orf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// The read data holds its value until the next read.
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
